>>> rtl/core/assert_macros.svh
// Assertion macros shared by the list core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define BST_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define BST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/bst_pkg.sv
// Types, sizes and codes shared by the list core modules.
package bst_pkg;

  localparam int DEPTH      = 64;
  localparam int ITEM_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int FIELD_W = 7;
  localparam int WORD_W  = 32;
  localparam int OP_W    = 3;

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam int CAP_RESET = 64;

  localparam logic REG_CAPACITY = 1'b0;

  typedef logic [ITEM_WIDTH-1:0] item_t;
  typedef logic [CNT_W-1:0]      cnt_t;
  typedef logic [ADDR_W-1:0]     addr_t;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_SORTED = 3'd1,
    OP_ERASE  = 3'd2,
    OP_REMOVE = 3'd3,
    OP_GET    = 3'd4,
    OP_SET    = 3'd5,
    OP_FIND   = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHUP,
    ST_SHDN,
    ST_PUT,
    ST_RD,
    ST_RDW,
    ST_DONE
  } state_t;

endpackage

>>> rtl/core/bst_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/bst_cfg.sv
// APB register block holding the list capacity.
module bst_cfg import bst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [FIELD_W-1:0] capacity
);

  logic [FIELD_W-1:0] capacity_r;
  logic               hit_cap;

  assign pready   = 1'b1;
  assign hit_cap  = (paddr[2] == REG_CAPACITY);
  assign capacity = capacity_r;
  assign prdata   = hit_cap ? PDATA_W'(capacity_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= FIELD_W'(CAP_RESET);
    end else if (psel && penable && pwrite && hit_cap) begin
      capacity_r <= pwdata[FIELD_W-1:0];
    end
  end

endmodule

>>> rtl/core/bounded_sequence_table_core.sv
// Top level of the list core: sequencer, store and register block.
//
// Ordered list of up to capacity items held in a single-port-pair RAM with a count.
// Raise start with in_op/in_pos/in_value while busy is low; the request is taken at
// that edge and busy stays high until the result has been shown. Each request gives
// exactly one result, on the out_ ports for one cycle with out_valid high; the
// receiver cannot stall it, so capture it in that cycle. Get reads the entry, set
// writes it. Insert shifts the entries from the position up one place, top first,
// then writes the value; erase shifts the entries above the position down one place.
// Find and remove-all walk the list from entry 0. Sorted insert walks to the first
// entry not below the value and inserts there, or appends at the end. Requests
// rejected up front (bad position, full list, unused code) go straight to the
// result. The store has one read and one write port, so every shift, compaction or
// search moves one entry per cycle through a single compare unit. Capacity is
// written over APB (register 0 at byte address 0) and should be changed only while
// busy is low; a capacity above the store depth acts as the depth. No clearing pass
// after reset: entries beyond the count are never read.
`include "assert_macros.svh"

module bounded_sequence_table_core import bst_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  // request channel
  input  logic               start,
  output logic               busy,
  input  logic [OP_W-1:0]    in_op,
  input  logic [FIELD_W-1:0] in_pos,
  input  logic [WORD_W-1:0]  in_value,
  // result channel
  output logic               out_valid,
  output logic               out_ok,
  output logic [FIELD_W-1:0] out_index,
  output logic [FIELD_W-1:0] out_removed_count,
  output logic [WORD_W-1:0]  out_read_value,
  output logic [FIELD_W-1:0] out_item_count,
  output logic               out_is_empty,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  item_t  value_r, value_nxt;
  cnt_t   count_r, count_nxt;
  cnt_t   tgt_r, tgt_nxt;     // insert position, or entry for get/set
  cnt_t   iss_r, iss_nxt;     // next read to issue (walk pointer)
  cnt_t   wptr_r, wptr_nxt;   // compaction write pointer for remove-all
  logic   rd_vld_r, rd_vld_nxt;
  cnt_t   rd_idx_r, rd_idx_nxt;

  logic   ok_r, ok_nxt;
  cnt_t   idx_r, idx_nxt;
  cnt_t   rem_r, rem_nxt;
  item_t  rdv_r, rdv_nxt;

  logic [FIELD_W-1:0] capacity;
  cnt_t               cap_eff;

  logic   mem_we, mem_re;
  addr_t  mem_waddr, mem_raddr;
  item_t  mem_wdata, mem_rdata;

  logic   val_eq, val_le;
  logic   ren;
  cnt_t   iss_dec;

  bst_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .capacity (capacity)
  );

  bst_ram #(
    .WIDTH (ITEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Clamp capacity to the store depth.
  always_comb begin
    if (32'(capacity) > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity);
    end
  end

  // Shared compare unit: request value against the entry just read.
  assign val_eq  = (value_r == mem_rdata);
  assign val_le  = (value_r <= mem_rdata);
  assign iss_dec = iss_r - CNT_W'(1);

  // Sequencer: next state, store access and result capture.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    value_nxt  = value_r;
    count_nxt  = count_r;
    tgt_nxt    = tgt_r;
    iss_nxt    = iss_r;
    wptr_nxt   = wptr_r;
    rd_vld_nxt = 1'b0;
    rd_idx_nxt = rd_idx_r;
    ok_nxt     = ok_r;
    idx_nxt    = idx_r;
    rem_nxt    = rem_r;
    rdv_nxt    = rdv_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = value_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    ren        = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt    = op_t'(in_op);
          value_nxt = item_t'(in_value);
          ok_nxt    = 1'b0;
          idx_nxt   = '0;
          rem_nxt   = '0;
          rdv_nxt   = '0;
          wptr_nxt  = '0;
          tgt_nxt   = CNT_W'(in_pos);
          state_nxt = ST_DONE;
          case (op_t'(in_op))
            OP_INSERT: begin
              if (32'(in_pos) <= 32'(count_r) && count_r < cap_eff) begin
                iss_nxt   = count_r;
                state_nxt = ST_SHUP;
              end
            end
            OP_SORTED: begin
              if (count_r < cap_eff) begin
                iss_nxt   = '0;
                state_nxt = ST_SCAN;
              end
            end
            OP_ERASE: begin
              if (32'(in_pos) < 32'(count_r)) begin
                iss_nxt   = CNT_W'(in_pos) + CNT_W'(1);
                state_nxt = ST_SHDN;
              end
            end
            OP_REMOVE, OP_FIND: begin
              iss_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            OP_GET: begin
              if (32'(in_pos) < 32'(count_r)) begin
                state_nxt = ST_RD;
              end
            end
            OP_SET: begin
              if (32'(in_pos) < 32'(count_r)) begin
                state_nxt = ST_PUT;
              end
            end
            default: begin
              // unused code: fail with state untouched
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Walk up from entry 0, one read per cycle.
        ren        = (iss_r < count_r);
        mem_re     = ren;
        mem_raddr  = iss_r[ADDR_W-1:0];
        rd_vld_nxt = ren;
        rd_idx_nxt = iss_r;
        if (ren) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          case (op_r)
            OP_SORTED: begin
              if (val_le) begin
                // first entry >= value: open a gap there
                tgt_nxt    = rd_idx_r;
                iss_nxt    = count_r;
                rd_vld_nxt = 1'b0;
                state_nxt  = ST_SHUP;
              end
            end
            OP_FIND: begin
              if (val_eq) begin
                ok_nxt     = 1'b1;
                idx_nxt    = rd_idx_r;
                rd_vld_nxt = 1'b0;
                state_nxt  = ST_DONE;
              end
            end
            OP_REMOVE: begin
              // keep non-matching entries, packed down
              if (!val_eq) begin
                mem_we    = 1'b1;
                mem_waddr = wptr_r[ADDR_W-1:0];
                mem_wdata = mem_rdata;
                wptr_nxt  = wptr_r + CNT_W'(1);
              end
            end
            default: begin
            end
          endcase
        end else if (!ren) begin
          case (op_r)
            OP_SORTED: begin
              tgt_nxt   = count_r;
              state_nxt = ST_PUT;
            end
            OP_REMOVE: begin
              rem_nxt   = count_r - wptr_r;
              count_nxt = wptr_r;
              ok_nxt    = (wptr_r != count_r);
              state_nxt = ST_DONE;
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_SHUP: begin
        // Move entries up by one, top first, down to the insert position.
        ren        = (iss_r > tgt_r);
        mem_re     = ren;
        mem_raddr  = iss_dec[ADDR_W-1:0];
        rd_vld_nxt = ren;
        rd_idx_nxt = iss_dec;
        if (ren) begin
          iss_nxt = iss_dec;
        end
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = addr_t'(rd_idx_r + CNT_W'(1));
          mem_wdata = mem_rdata;
        end else if (!ren) begin
          state_nxt = ST_PUT;
        end
      end

      ST_SHDN: begin
        // Move entries above the erased one down by one.
        ren        = (iss_r < count_r);
        mem_re     = ren;
        mem_raddr  = iss_r[ADDR_W-1:0];
        rd_vld_nxt = ren;
        rd_idx_nxt = iss_r;
        if (ren) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        if (rd_vld_r) begin
          mem_we    = 1'b1;
          mem_waddr = addr_t'(rd_idx_r - CNT_W'(1));
          mem_wdata = mem_rdata;
        end else if (!ren) begin
          count_nxt = count_r - CNT_W'(1);
          ok_nxt    = 1'b1;
          state_nxt = ST_DONE;
        end
      end

      ST_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = tgt_r[ADDR_W-1:0];
        mem_wdata = value_r;
        ok_nxt    = 1'b1;
        if (op_r != OP_SET) begin
          count_nxt = count_r + CNT_W'(1);
          idx_nxt   = tgt_r;
        end
        state_nxt = ST_DONE;
      end

      ST_RD: begin
        mem_re    = 1'b1;
        mem_raddr = tgt_r[ADDR_W-1:0];
        state_nxt = ST_RDW;
      end

      ST_RDW: begin
        rdv_nxt   = mem_rdata;
        ok_nxt    = 1'b1;
        state_nxt = ST_DONE;
      end

      ST_DONE: begin
        state_nxt = ST_IDLE;
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      count_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      count_r  <= count_nxt;
      rd_vld_r <= rd_vld_nxt;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    value_r  <= value_nxt;
    tgt_r    <= tgt_nxt;
    iss_r    <= iss_nxt;
    wptr_r   <= wptr_nxt;
    rd_idx_r <= rd_idx_nxt;
    ok_r     <= ok_nxt;
    idx_r    <= idx_nxt;
    rem_r    <= rem_nxt;
    rdv_r    <= rdv_nxt;
  end

  assign busy              = (state_r != ST_IDLE);
  assign out_valid         = (state_r == ST_DONE);
  assign out_ok            = ok_r;
  assign out_index         = FIELD_W'(idx_r);
  assign out_removed_count = FIELD_W'(rem_r);
  assign out_read_value    = WORD_W'(rdv_r);
  assign out_item_count    = FIELD_W'(count_r);
  assign out_is_empty      = (count_r == '0);

  `BST_ASSERT_SAME(a_count_bound, 1'b1, count_r <= CNT_W'(DEPTH), "count above depth")
  `BST_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request not held")
  `BST_ASSERT_NEXT(a_result_ends, out_valid, !busy, "still busy after result")
  `BST_ASSERT_SAME(a_count_moves, count_r != $past(count_r), $past(busy), "idle count change")

endmodule

>>> verif/tb_top.sv
// Self-checking testbench for the bounded sequence table core: list requests and capacity writes.
module tb_top;
  import bst_pkg::*;

  // Op code 7 has no operation behind it; the core answers with a failed result.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  // Slowest correct run is about 1900 requests plus sender gaps; allow several times that.
  localparam int CYCLE_LIMIT  = 800_000;
  localparam int SETTLE_TICKS = 80;
  localparam int SEGMENTS     = 12;
  localparam int SEG_REQUESTS = 155;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic               ok;
    logic [FIELD_W-1:0] index;
    logic [FIELD_W-1:0] removed;
    logic [WORD_W-1:0]  read_value;
    logic [FIELD_W-1:0] item_count;
    logic               is_empty;
  } list_result_t;

  // One line of the directed table: a request (optionally with a typed-in answer)
  // or a capacity write, whose value rides in the value column.
  typedef struct packed {
    row_kind_t          kind;
    logic [OP_W-1:0]    op;
    logic [FIELD_W-1:0] pos;
    logic [WORD_W-1:0]  value;
    logic               typed;
    list_result_t       want;
  } plan_row_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [OP_W-1:0]    in_op;
  logic [FIELD_W-1:0] in_pos;
  logic [WORD_W-1:0]  in_value;
  logic               out_valid;
  logic               out_ok;
  logic [FIELD_W-1:0] out_index;
  logic [FIELD_W-1:0] out_removed_count;
  logic [WORD_W-1:0]  out_read_value;
  logic [FIELD_W-1:0] out_item_count;
  logic               out_is_empty;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Shadow copy of the list: entries, length and the capacity register.
  item_t        shadow_list [DEPTH];
  int unsigned  held_len;
  int unsigned  shadow_cap;

  // Results still owed by the core, oldest first.
  list_result_t pending_outcomes [$];

  item_t        value_pool [8];
  int           error_count;
  int unsigned  cycle_count;

  bounded_sequence_table_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_pos            (in_pos),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_ok            (out_ok),
    .out_index         (out_index),
    .out_removed_count (out_removed_count),
    .out_read_value    (out_read_value),
    .out_item_count    (out_item_count),
    .out_is_empty      (out_is_empty),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop: a hung handshake or a lost result must not run forever.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic list_result_t outcome(input logic ok, input int idx, input int rem,
                                           input logic [WORD_W-1:0] rd, input int cnt);
    list_result_t r;
    r.ok         = ok;
    r.index      = FIELD_W'(idx);
    r.removed    = FIELD_W'(rem);
    r.read_value = rd;
    r.item_count = FIELD_W'(cnt);
    r.is_empty   = (cnt == 0);
    return r;
  endfunction

  function automatic plan_row_t req(input logic [OP_W-1:0] op, input int pos,
                                    input logic [WORD_W-1:0] value);
    plan_row_t row;
    row.kind  = ROW_REQ;
    row.op    = op;
    row.pos   = FIELD_W'(pos);
    row.value = value;
    row.typed = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic plan_row_t chk(input logic [OP_W-1:0] op, input int pos,
                                    input logic [WORD_W-1:0] value, input list_result_t want);
    plan_row_t row;
    row       = req(op, pos, value);
    row.typed = 1'b1;
    row.want  = want;
    return row;
  endfunction

  function automatic plan_row_t cfg(input int cap);
    plan_row_t row;
    row       = req(OP_INSERT, 0, WORD_W'(cap));
    row.kind  = ROW_CFG;
    return row;
  endfunction

  // Open a hole at slot by moving the tail up one place, then drop the value in.
  function automatic void shift_in(input int unsigned slot, input item_t value);
    int unsigned i;
    for (i = held_len; i > slot; i--) shadow_list[i] = shadow_list[i - 1];
    shadow_list[slot] = value;
    held_len++;
  endfunction

  // Apply one request to the shadow list and return the result the core must give.
  function automatic list_result_t list_apply(input logic [OP_W-1:0] op,
                                              input logic [FIELD_W-1:0] pos,
                                              input item_t value);
    list_result_t r;
    int unsigned  room;
    int unsigned  slot;
    int unsigned  kept;
    int unsigned  i;
    r    = '0;
    room = (shadow_cap > DEPTH) ? DEPTH : shadow_cap;
    case (op)
      OP_INSERT: begin
        if (pos <= held_len && held_len < room) begin
          shift_in(pos, value);
          r.ok    = 1'b1;
          r.index = pos;
        end
      end
      OP_SORTED: begin
        if (held_len < room) begin
          slot = held_len;
          for (i = 0; i < held_len && slot == held_len; i++)
            if (value <= shadow_list[i]) slot = i;
          shift_in(slot, value);
          r.ok    = 1'b1;
          r.index = FIELD_W'(slot);
        end
      end
      OP_ERASE: begin
        if (pos < held_len) begin
          for (i = pos; i + 1 < held_len; i++) shadow_list[i] = shadow_list[i + 1];
          held_len--;
          r.ok = 1'b1;
        end
      end
      OP_REMOVE: begin
        kept = 0;
        for (i = 0; i < held_len; i++) begin
          if (shadow_list[i] != value) begin
            shadow_list[kept] = shadow_list[i];
            kept++;
          end
        end
        r.removed = FIELD_W'(held_len - kept);
        r.ok      = (kept != held_len);
        held_len  = kept;
      end
      OP_GET: begin
        if (pos < held_len) begin
          r.read_value = shadow_list[pos];
          r.ok         = 1'b1;
        end
      end
      OP_SET: begin
        if (pos < held_len) begin
          shadow_list[pos] = value;
          r.ok             = 1'b1;
        end
      end
      OP_FIND: begin
        slot = held_len;
        for (i = 0; i < held_len && slot == held_len; i++)
          if (shadow_list[i] == value) slot = i;
        if (slot != held_len) begin
          r.ok    = 1'b1;
          r.index = FIELD_W'(slot);
        end
      end
      default: ;
    endcase
    r.item_count = FIELD_W'(held_len);
    r.is_empty   = (held_len == 0);
    return r;
  endfunction

  // Present a request at the falling edge and hold it until the core takes it.
  task automatic issue_request(input logic [OP_W-1:0] op, input logic [FIELD_W-1:0] pos,
                               input item_t value);
    @(negedge clk);
    start    = 1'b1;
    in_op    = op;
    in_pos   = pos;
    in_value = value;
    do @(posedge clk); while (busy);
  endtask

  // Write the capacity register once the core is idle, then read it back.
  task automatic set_capacity(input logic [FIELD_W-1:0] cap);
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0 || busy !== 1'b0) @(posedge clk);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = PADDR_W'(4 * REG_CAPACITY);
    pwdata  = PDATA_W'(cap);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    shadow_cap = cap;
    @(negedge clk);
    penable = 1'b0;
    pwrite  = 1'b0;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== PDATA_W'(cap)) begin
      $error("capacity readback: expected %0d, got %0d", cap, prdata);
      error_count++;
    end
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // Choose a random request. While the list is below its fill goal, lean on inserts;
  // above it, lean on erase and remove. Most positions are in range, most values come
  // from a small pool so that find and remove actually hit.
  task automatic pick_request(input int unsigned fill_goal, output logic [OP_W-1:0] op,
                              output logic [FIELD_W-1:0] pos, output item_t value);
    int unsigned w;
    w = $urandom_range(99);
    if (w < 3) begin
      op = OP_UNUSED;
    end else if (held_len < fill_goal) begin
      w  = $urandom_range(99);
      op = (w < 30) ? OP_INSERT : (w < 60) ? OP_SORTED : (w < 63) ? OP_ERASE :
           (w < 65) ? OP_REMOVE : (w < 78) ? OP_GET : (w < 88) ? OP_SET : OP_FIND;
    end else begin
      w  = $urandom_range(99);
      op = (w < 10) ? OP_INSERT : (w < 20) ? OP_SORTED : (w < 45) ? OP_ERASE :
           (w < 57) ? OP_REMOVE : (w < 72) ? OP_GET : (w < 84) ? OP_SET : OP_FIND;
    end

    if ($urandom_range(99) < 8)
      pos = FIELD_W'($urandom_range(127));
    else if (op == OP_INSERT)
      pos = FIELD_W'($urandom_range(held_len));
    else
      pos = (held_len == 0) ? '0 : FIELD_W'($urandom_range(held_len - 1));

    w = $urandom_range(99);
    if (w < 55)
      value = value_pool[$urandom_range(7)];
    else if (w < 75 && held_len > 0)
      value = shadow_list[$urandom_range(held_len - 1)];
    else
      value = $urandom;
  endtask

  // Compare every strobed result with the oldest expectation, field by field.
  always @(posedge clk) begin
    list_result_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_outcomes.size() == 0) begin
        $error("result with no request outstanding");
        error_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (out_ok !== want.ok) begin
          $error("ok: expected %0d, got %0d", want.ok, out_ok);
          error_count++;
        end
        if (out_index !== want.index) begin
          $error("index: expected %0d, got %0d", want.index, out_index);
          error_count++;
        end
        if (out_removed_count !== want.removed) begin
          $error("removed_count: expected %0d, got %0d", want.removed, out_removed_count);
          error_count++;
        end
        if (out_read_value !== want.read_value) begin
          $error("read_value: expected %h, got %h", want.read_value, out_read_value);
          error_count++;
        end
        if (out_item_count !== want.item_count) begin
          $error("item_count: expected %0d, got %0d", want.item_count, out_item_count);
          error_count++;
        end
        if (out_is_empty !== want.is_empty) begin
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_is_empty);
          error_count++;
        end
      end
    end
  end

  initial begin
    plan_row_t         directed_plan [26];
    list_result_t      predicted;
    logic [OP_W-1:0]   op;
    logic [FIELD_W-1:0] pos;
    item_t             value;
    int unsigned       cap_plan [SEGMENTS];
    int unsigned       fill_goal;
    int unsigned       idle_pct;

    // Drive every input to a known value before the first edge.
    start    = 1'b0;
    in_op    = '0;
    in_pos   = '0;
    in_value = '0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    rst_n    = 1'b0;

    error_count = 0;
    held_len    = 0;
    shadow_cap  = CAP_RESET;
    foreach (shadow_list[i]) shadow_list[i] = '0;

    // Directed part: empty-list failures, the unused op code, extreme values and
    // positions, insert at the very end, capacity at the count and above the depth.
    directed_plan = '{
      chk(OP_GET,    0,   32'h0,         outcome(0, 0, 0, 32'h0, 0)),
      chk(OP_ERASE,  0,   32'h0,         outcome(0, 0, 0, 32'h0, 0)),
      chk(OP_SET,    0,   32'h1,         outcome(0, 0, 0, 32'h0, 0)),
      chk(OP_FIND,   0,   32'h0,         outcome(0, 0, 0, 32'h0, 0)),
      chk(OP_REMOVE, 0,   32'h0,         outcome(0, 0, 0, 32'h0, 0)),
      chk(OP_UNUSED, 0,   32'h0,         outcome(0, 0, 0, 32'h0, 0)),
      chk(OP_INSERT, 1,   32'h5,         outcome(0, 0, 0, 32'h0, 0)),
      chk(OP_INSERT, 0,   32'hFFFF_FFFF, outcome(1, 0, 0, 32'h0, 1)),
      chk(OP_SORTED, 0,   32'h0,         outcome(1, 0, 0, 32'h0, 2)),
      req(OP_SORTED, 0,   32'h8000_0000),
      chk(OP_SORTED, 0,   32'hFFFF_FFFF, outcome(1, 2, 0, 32'h0, 4)),
      chk(OP_GET,    3,   32'h0,         outcome(1, 0, 0, 32'hFFFF_FFFF, 4)),
      chk(OP_FIND,   0,   32'hFFFF_FFFF, outcome(1, 2, 0, 32'h0, 4)),
      req(OP_SET,    0,   32'h1234_5678),
      chk(OP_INSERT, 4,   32'h5,         outcome(1, 4, 0, 32'h0, 5)),
      chk(OP_INSERT, 127, 32'h7,         outcome(0, 0, 0, 32'h0, 5)),
      chk(OP_REMOVE, 0,   32'hFFFF_FFFF, outcome(1, 0, 2, 32'h0, 3)),
      req(OP_ERASE,  2,   32'h0),
      chk(OP_ERASE,  2,   32'h0,         outcome(0, 0, 0, 32'h0, 2)),
      chk(OP_GET,    1,   32'h0,         outcome(1, 0, 0, 32'h8000_0000, 2)),
      chk(OP_UNUSED, 127, 32'hFFFF_FFFF, outcome(0, 0, 0, 32'h0, 2)),
      cfg(2),
      chk(OP_INSERT, 0,   32'h1,         outcome(0, 0, 0, 32'h0, 2)),
      chk(OP_SORTED, 0,   32'h0,         outcome(0, 0, 0, 32'h0, 2)),
      cfg(127),
      chk(OP_SORTED, 0,   32'h0,         outcome(1, 0, 0, 32'h0, 3))
    };

    // Capacity per random segment: reset value, above the depth, zero, one, small odd
    // values, and one draw that usually lands below a well-filled list.
    cap_plan = '{64, 5, 127, 64, 0, 17, 64, 127, 1, 64, 0, 64};
    cap_plan[10] = $urandom_range(40, 2);

    // Hold reset low, then release it at a falling edge.
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Walk the directed table. Typed rows check against the typed answer; the shadow
    // list still advances so the random part starts from the right state.
    foreach (directed_plan[r]) begin
      if (directed_plan[r].kind == ROW_CFG) begin
        set_capacity(directed_plan[r].value[FIELD_W-1:0]);
      end else begin
        issue_request(directed_plan[r].op, directed_plan[r].pos, directed_plan[r].value);
        predicted = list_apply(directed_plan[r].op, directed_plan[r].pos,
                               directed_plan[r].value);
        pending_outcomes.push_back(directed_plan[r].typed ? directed_plan[r].want : predicted);
      end
    end

    // Random part. Sender idles 21% of cycles, then 65%, then never.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      set_capacity(FIELD_W'(cap_plan[seg]));
      value_pool[0] = '0;
      value_pool[1] = '1;
      for (int k = 2; k < 8; k++) value_pool[k] = $urandom;
      fill_goal = (seg % 2 == 0) ? DEPTH : $urandom_range(DEPTH);
      idle_pct  = (seg < 4) ? 21 : (seg < 8) ? 65 : 0;
      for (int n = 0; n < SEG_REQUESTS; n++) begin
        // Drop start for a random stretch before the next request.
        while ($urandom_range(99) < idle_pct) begin
          @(negedge clk);
          start = 1'b0;
        end
        pick_request(fill_goal, op, pos, value);
        issue_request(op, pos, value);
        pending_outcomes.push_back(list_apply(op, pos, value));
      end
    end

    // Drain: release start, wait for every owed result, then let the core settle.
    @(negedge clk);
    start = 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
